FILE: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the epoch-to-calendar converter
// Field widths, calendar constants, divider reciprocals, controller/datapath
// command and status structs, and the days-before-month table.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int EPOCH_W = 38;
    localparam int DAY_W   = 22;   // day count of a 38-bit second count
    localparam int TOD_W   = 17;   // seconds within a day
    localparam int MINS_W  = 11;   // minutes within a day
    localparam int YEAR_W  = 14;
    localparam int YDAY_W  = 9;
    localparam int MON_W   = 4;
    localparam int MDAY_W  = 5;
    localparam int SEC_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int WDAY_W  = 3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    localparam int EPOCH_YEAR = 1970;

    localparam logic [TOD_W-1:0]  SECS_PER_DAY = TOD_W'(24 * 60 * 60);
    localparam logic [TOD_W-1:0]  SIXTY        = TOD_W'(60);
    localparam logic [TOD_W-1:0]  DAYS_PER_WK  = TOD_W'(7);
    localparam logic [DAY_W-1:0]  WDAY_AT_EPOCH = DAY_W'(4);  // Thursday

    // 86400 = 675 * 2^7: the day pass drops 7 low bits and divides by 675
    localparam int                DAY_SHIFT = 7;
    localparam logic [TOD_W-1:0]  DAY_ODD   = SECS_PER_DAY >> DAY_SHIFT;
    localparam int                X_W       = EPOCH_W - DAY_SHIFT;
    localparam int                RECIP_W   = 32;
    localparam int                PROD_W    = X_W + RECIP_W;

    // q = (x * ceil(2^k / d)) >> k is exact while x * (slack) < 2^k;
    // k covers 31-bit x for 675, 17-bit x for 60 and 23-bit x for 7
    localparam int SH_DAY   = 41;
    localparam int SH_SIXTY = 23;
    localparam int SH_WEEK  = 26;

    localparam logic [RECIP_W-1:0] RECIP_DAY = RECIP_W'(
        ((64'd1 << SH_DAY) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
    localparam logic [RECIP_W-1:0] RECIP_SIXTY = RECIP_W'(
        ((64'd1 << SH_SIXTY) + 64'(SIXTY) - 64'd1) / 64'(SIXTY));
    localparam logic [RECIP_W-1:0] RECIP_WEEK = RECIP_W'(
        ((64'd1 << SH_WEEK) + 64'(DAYS_PER_WK) - 64'd1) / 64'(DAYS_PER_WK));

    localparam logic [YEAR_W-1:0] EPOCH_YEAR_V = YEAR_W'(EPOCH_YEAR);
    localparam logic [6:0]        EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0]        EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);

    localparam logic [YDAY_W-1:0] LEAP_LEN   = YDAY_W'(366);
    localparam logic [YDAY_W-1:0] COMMON_LEN = YDAY_W'(365);
    localparam logic [YDAY_W-1:0] FEB28_YDAY = YDAY_W'(58);
    localparam logic [YDAY_W-1:0] FEB29_YDAY = YDAY_W'(59);
    localparam logic [MON_W-1:0]  LAST_MONTH = MON_W'(11);

    // divider pass select
    localparam logic [1:0] DIV_DAY  = 2'd0;
    localparam logic [1:0] DIV_SEC  = 2'd1;
    localparam logic [1:0] DIV_MIN  = 2'd2;
    localparam logic [1:0] DIV_WEEK = 2'd3;

    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_sel;
        logic       year_init;
        logic       year_step;
        logic       month_calc;
        logic       out_load;
    } esc_cmd_t;

    typedef struct packed {
        logic div_idle;
        logic year_found;
        logic year_over;
    } esc_status_t;

    function automatic logic [YDAY_W-1:0] days_before_month(input logic [MON_W-1:0] m);
        logic [YDAY_W-1:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/epoch_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core: seconds since 1970 to UTC calendar fields
// Stream in a second count, stream out time of day, weekday, year, day of
// year, month and day of month, with a flag for counts past MAX_YEAR.
// ----------------------------------------------------------------------------
// One count is converted at a time. After the input transfer the block runs
// four passes of a shared constant divider (day count, seconds, minutes,
// weekday), each a reciprocal multiply, shift and back-multiply, then takes
// whole years off the day count at one year per clock, then does the month
// lookup and loads the result register. The year subtraction loop sets the
// rate. A result still waiting on the output holds the next count in its
// final step, before the result register is loaded, until it is taken.
// A new count is taken while the previous result still waits on the output.
// Counts past the end of MAX_YEAR set tuser and return zero in the date fields.
module epoch_seconds_to_calendar_core
    import esc_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [37:0] epoch_seconds, [39:38] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
    // [19:17] weekday, [33:20] full_year, [42:34] day_of_year,
    // [46:43] month_index, [51:47] day_of_month, [55:52] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] range_error
    output logic                 m_tuser
);

    esc_cmd_t    cmd;
    esc_status_t status;

    esc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    esc_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .epoch_in     (s_tdata[EPOCH_W-1:0]),
        .result_data  (m_tdata),
        .result_range (m_tuser)
    );

endmodule

FILE: rtl/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div: constant divider by reciprocal multiplication
// Divides by 86400, 60 or 7 as the pass select says: multiply, shift, then
// back-multiply for the remainder; idle rises when the results are ready.
// ----------------------------------------------------------------------------
module esc_div
    import esc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [1:0]         sel,
    input  logic [EPOCH_W-1:0] dividend,
    output logic               idle,
    output logic [DAY_W-1:0]   quotient,
    output logic [TOD_W-1:0]   remainder
);

    localparam int BACK_W = DAY_W + TOD_W;

    // countdown of the three steps after start
    localparam logic [1:0] STEP_MUL = 2'd3;
    localparam logic [1:0] STEP_QUO = 2'd2;
    localparam logic [1:0] STEP_REM = 2'd1;

    logic [1:0]           step_reg, step_next;
    logic [1:0]           sel_reg;
    logic [X_W-1:0]       x_reg;
    logic [DAY_SHIFT-1:0] low_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [DAY_W-1:0]     quo_reg;
    logic [TOD_W-1:0]     rem_reg;

    logic [RECIP_W-1:0]   recip;
    logic [TOD_W-1:0]     dvs;
    logic [DAY_W-1:0]     quo_shift;
    logic [BACK_W-1:0]    back;
    logic [X_W-1:0]       part;
    logic [TOD_W-1:0]     rem_val;

    always_comb begin
        unique case (sel_reg)
            DIV_DAY: begin
                recip     = RECIP_DAY;
                dvs       = DAY_ODD;
                quo_shift = DAY_W'(prod_reg >> SH_DAY);
            end
            DIV_SEC: begin
                recip     = RECIP_SIXTY;
                dvs       = SIXTY;
                quo_shift = DAY_W'(prod_reg >> SH_SIXTY);
            end
            DIV_MIN: begin
                recip     = RECIP_SIXTY;
                dvs       = SIXTY;
                quo_shift = DAY_W'(prod_reg >> SH_SIXTY);
            end
            DIV_WEEK: begin
                recip     = RECIP_WEEK;
                dvs       = DAYS_PER_WK;
                quo_shift = DAY_W'(prod_reg >> SH_WEEK);
            end
        endcase
        back = BACK_W'(quo_reg) * BACK_W'(dvs);
        part = x_reg - back[X_W-1:0];
        // day pass: the dropped low bits go back under the remainder by 675
        if (sel_reg == DIV_DAY) begin
            rem_val = {part[TOD_W-DAY_SHIFT-1:0], low_reg};
        end else begin
            rem_val = part[TOD_W-1:0];
        end
    end

    always_comb begin
        step_next = step_reg;
        if (start) begin
            step_next = STEP_MUL;
        end else if (step_reg != '0) begin
            step_next = step_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sel_reg <= sel;
            x_reg   <= (sel == DIV_DAY) ? dividend[EPOCH_W-1:DAY_SHIFT]
                                        : dividend[X_W-1:0];
            low_reg <= dividend[DAY_SHIFT-1:0];
        end
        if (step_reg == STEP_MUL) begin
            prod_reg <= PROD_W'(x_reg) * PROD_W'(recip);
        end
        if (step_reg == STEP_QUO) begin
            quo_reg <= quo_shift;
        end
        if (step_reg == STEP_REM) begin
            rem_reg <= rem_val;
        end
    end

    assign idle      = (step_reg == '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/esc_datapath.sv
// ----------------------------------------------------------------------------
// esc_datapath: arithmetic of the epoch-to-calendar converter
// Divider passes for time of day and weekday, the year subtraction loop with
// leap-rule counters, month lookup and the result register.
// ----------------------------------------------------------------------------
module esc_datapath
    import esc_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  esc_cmd_t             cmd,
    output esc_status_t          status,
    input  logic [EPOCH_W-1:0]   epoch_in,
    output logic [M_TDATA_W-1:0] result_data,
    output logic                 result_range
);

    logic [EPOCH_W-1:0] epoch_reg;
    logic [DAY_W-1:0]   days_reg;
    logic [TOD_W-1:0]   tod_reg;
    logic [MINS_W-1:0]  mins_reg;
    logic [SEC_W-1:0]   sec_reg;
    logic [SEC_W-1:0]   min_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [WDAY_W-1:0]  wday_reg;

    logic [DAY_W-1:0]   left_reg;   // days left after whole years
    logic [YEAR_W-1:0]  year_reg;
    logic [6:0]         c100_reg;
    logic [8:0]         c400_reg;

    logic [YDAY_W-1:0]  yday_reg;
    logic [MON_W-1:0]   mon_reg;
    logic [MDAY_W-1:0]  mday_reg;

    logic [M_TDATA_W-1:0] data_reg;
    logic                 range_reg;

    // divider hookup
    logic [EPOCH_W-1:0] div_dividend;
    logic               div_idle;
    logic [DAY_W-1:0]   div_quo;
    logic [TOD_W-1:0]   div_rem;

    always_comb begin
        unique case (cmd.div_sel)
            DIV_DAY: begin
                div_dividend = epoch_reg;
            end
            DIV_SEC: begin
                div_dividend = EPOCH_W'(tod_reg);
            end
            DIV_MIN: begin
                div_dividend = EPOCH_W'(mins_reg);
            end
            DIV_WEEK: begin
                div_dividend = EPOCH_W'(days_reg) + EPOCH_W'(WDAY_AT_EPOCH);
            end
            default: begin
                div_dividend = epoch_reg;
            end
        endcase
    end

    esc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .sel       (cmd.div_sel),
        .dividend  (div_dividend),
        .idle      (div_idle),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // leap rule from running year residues
    logic              leap;
    logic [YDAY_W-1:0] year_len;
    logic              year_over;
    logic              year_found;

    assign leap       = (year_reg[1:0] == 2'd0) && ((c100_reg != 7'd0) || (c400_reg == 9'd0));
    assign year_len   = leap ? LEAP_LEN : COMMON_LEN;
    assign year_over  = (year_reg > YEAR_W'(MAX_YEAR));
    assign year_found = !year_over && (left_reg < DAY_W'(year_len));

    assign status.div_idle   = div_idle;
    assign status.year_found = year_found;
    assign status.year_over  = year_over;

    // month lookup: day of year folded onto a common year
    logic [YDAY_W-1:0] yday_w;
    logic [YDAY_W-1:0] w;
    logic [MDAY_W-1:0] mday_base;
    logic [MON_W-1:0]  mon_sel;
    logic [YDAY_W-1:0] mday_full;

    assign yday_w = left_reg[YDAY_W-1:0];

    always_comb begin
        w         = yday_w;
        mday_base = MDAY_W'(1);
        if (leap && (yday_w > FEB28_YDAY)) begin
            if (yday_w == FEB29_YDAY) begin
                mday_base = MDAY_W'(2);
            end
            w = yday_w - YDAY_W'(1);
        end
        // table is increasing, so the month is the count of later starts passed
        mon_sel = '0;
        for (int i = 1; i <= 11; i++) begin
            if (days_before_month(MON_W'(i)) <= w) begin
                mon_sel = mon_sel + MON_W'(1);
            end
        end
        mday_full = YDAY_W'(mday_base) + w - days_before_month(mon_sel);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            epoch_reg <= epoch_in;
        end
        if (cmd.div_store) begin
            case (cmd.div_sel)
                DIV_DAY: begin
                    days_reg <= div_quo;
                    tod_reg  <= div_rem;
                end
                DIV_SEC: begin
                    mins_reg <= div_quo[MINS_W-1:0];
                    sec_reg  <= div_rem[SEC_W-1:0];
                end
                DIV_MIN: begin
                    hour_reg <= div_quo[HOUR_W-1:0];
                    min_reg  <= div_rem[SEC_W-1:0];
                end
                default: begin
                    wday_reg <= div_rem[WDAY_W-1:0];
                end
            endcase
        end
        if (cmd.year_init) begin
            left_reg <= days_reg;
            year_reg <= EPOCH_YEAR_V;
            c100_reg <= EPOCH_MOD100;
            c400_reg <= EPOCH_MOD400;
        end else if (cmd.year_step) begin
            left_reg <= left_reg - DAY_W'(year_len);
            year_reg <= year_reg + YEAR_W'(1);
            c100_reg <= (c100_reg == 7'd99)  ? 7'd0 : c100_reg + 7'd1;
            c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
        end
        if (cmd.month_calc) begin
            yday_reg <= yday_w;
            mon_reg  <= (mon_sel > LAST_MONTH) ? LAST_MONTH : mon_sel;
            mday_reg <= mday_full[MDAY_W-1:0];
        end
        if (cmd.out_load) begin
            range_reg <= year_over;
            data_reg  <= {4'd0,
                          year_over ? MDAY_W'(0) : mday_reg,
                          year_over ? MON_W'(0)  : mon_reg,
                          year_over ? YDAY_W'(0) : yday_reg,
                          year_over ? YEAR_W'(0) : year_reg,
                          wday_reg, hour_reg, min_reg, sec_reg};
        end
    end

    assign result_data  = data_reg;
    assign result_range = range_reg;

endmodule

FILE: rtl/esc_ctrl.sv
// ----------------------------------------------------------------------------
// esc_ctrl: sequencer of the epoch-to-calendar converter
// Runs the four divider passes, the year loop and the month step, and owns
// both handshakes and the result valid flag.
// ----------------------------------------------------------------------------
module esc_ctrl
    import esc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output esc_cmd_t    cmd,
    input  esc_status_t status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DSTART = 3'd1;
    localparam logic [2:0] S_DRUN   = 3'd2;
    localparam logic [2:0] S_DSTORE = 3'd3;
    localparam logic [2:0] S_YEAR   = 3'd4;
    localparam logic [2:0] S_MONTH  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    sel_next    = DIV_DAY;
                    state_next  = S_DSTART;
                end
            end
            S_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = S_DRUN;
            end
            S_DRUN: begin
                if (status.div_idle) begin
                    state_next = S_DSTORE;
                end
            end
            S_DSTORE: begin
                cmd.div_store = 1'b1;
                if (sel_reg == DIV_WEEK) begin
                    cmd.year_init = 1'b1;
                    state_next    = S_YEAR;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_DSTART;
                end
            end
            S_YEAR: begin
                if (status.year_found) begin
                    state_next = S_MONTH;
                end else if (status.year_over) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                cmd.month_calc = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            sel_reg    <= DIV_DAY;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule
